### rtl/btlpm_pkg.sv
// ----------------------------------------------------------------------------
// btlpm_pkg
// Shared types and constants for the binary trie longest prefix match core.
// ----------------------------------------------------------------------------
package btlpm_pkg;

  // default sizes
  localparam int unsigned NodeCountDefault = 1024;
  localparam int unsigned AddrBitsDefault  = 32;

  // fixed field widths
  localparam int unsigned NetW   = 32;
  localparam int unsigned LenW   = 6;
  localparam int unsigned CountW = 11;
  // level counter and saturated prefix length, wide enough for 64 levels
  localparam int unsigned LvlW   = 7;

  // command queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_e;

  // one classified command as queued for the back end
  typedef struct packed {
    cmd_e               cmd;
    logic [NetW-1:0]    addr;
    logic [LvlW-1:0]    plen;
  } item_t;

endpackage

### rtl/btlpm_front.sv
// ----------------------------------------------------------------------------
// btlpm_front
// Takes commands, saturates the prefix length and queues them for the back.
// ----------------------------------------------------------------------------
module btlpm_front #(
  parameter int unsigned ADDR_BITS = btlpm_pkg::AddrBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               command_i,
  input  logic [btlpm_pkg::NetW-1:0] address_i,
  input  logic [btlpm_pkg::LenW-1:0] prefix_len_i,
  output logic                     item_valid_o,
  output btlpm_pkg::item_t         item_o,
  input  logic                     item_pop_i
);
  import btlpm_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t             queue_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic              push;
  item_t             item_in;
  logic [7:0]        plen_ext;

  // classify: saturate the prefix length to the trie depth
  always_comb begin
    plen_ext     = 8'(prefix_len_i);
    item_in.cmd  = cmd_e'(command_i);
    item_in.addr = address_i;
    if (plen_ext > 8'(ADDR_BITS)) begin
      item_in.plen = LvlW'(ADDR_BITS);
    end else begin
      item_in.plen = LvlW'(plen_ext);
    end
  end

  assign busy_o       = (fill_q == CntW'(QueueDepth));
  assign push         = start_i && !busy_o;
  assign item_valid_o = (fill_q != '0);
  assign item_o       = queue_q[rd_ptr_q];

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (item_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !item_pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (!push && item_pop_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

### rtl/btlpm_back.sv
// ----------------------------------------------------------------------------
// btlpm_back
// Walks the trie in the node memory, one level per cycle, and forms results.
// ----------------------------------------------------------------------------
module btlpm_back #(
  parameter int unsigned NODE_COUNT = btlpm_pkg::NodeCountDefault,
  parameter int unsigned ADDR_BITS  = btlpm_pkg::AddrBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  input  btlpm_pkg::item_t             item_i,
  output logic                         item_pop_o,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [btlpm_pkg::NetW-1:0]   route_net_o,
  output logic [btlpm_pkg::LenW-1:0]   route_len_o,
  output logic                         is_route_o,
  output logic [btlpm_pkg::CountW-1:0] route_count_o
);
  import btlpm_pkg::*;

  localparam int unsigned NW  = $clog2(NODE_COUNT);
  localparam int unsigned FW  = NW + 1;
  localparam int unsigned CW  = $clog2(NODE_COUNT + 1);
  localparam int unsigned PW  = $clog2(ADDR_BITS);

  typedef struct packed {
    logic [NW-1:0]   child0;
    logic [NW-1:0]   child1;
    logic            route;
    logic [NetW-1:0] net;
    logic [LenW-1:0] len;
  } node_t;

  // node memory
  node_t           mem [NODE_COUNT];
  node_t           rdata_q;
  logic            rd_root_q;
  logic            rd_en;
  logic [NW-1:0]   rd_addr;
  logic            wr_en;
  logic [NW-1:0]   wr_addr;
  node_t           wr_data;

  // walk state
  back_state_e     state_q, state_d;
  item_t           item_q, item_d;
  logic [NW-1:0]   cur_q, cur_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  node_t           node_reg_q, node_reg_d;
  logic            use_reg_q, use_reg_d;
  logic            found_q, found_d;
  logic [NetW-1:0] best_net_q, best_net_d;
  logic [LenW-1:0] best_len_q, best_len_d;
  logic [FW-1:0]   next_free_q, next_free_d;
  logic [CW-1:0]   count_q, count_d;
  logic            root_valid_q, root_valid_d;

  // result register
  logic            res_valid_q, res_valid_d;
  status_e         res_status_q, res_status_d;
  logic [NetW-1:0] res_net_q, res_net_d;
  logic [LenW-1:0] res_len_q, res_len_d;
  logic            res_route_q, res_route_d;
  logic [CountW-1:0] res_count_q, res_count_d;

  // current node and path bit
  node_t           node;
  logic [PW-1:0]   pos;
  logic [6:0]      pos_ext;
  logic            path_bit;
  logic [NW-1:0]   child;
  logic            child_ok;
  logic            pool_full;
  logic            route_here;
  node_t           upd;

  assign node      = use_reg_q ? node_reg_q : (rd_root_q ? '0 : rdata_q);
  assign pos       = PW'(ADDR_BITS - 1) - PW'(lvl_q);
  assign pos_ext   = 7'(pos);
  assign path_bit  = (pos_ext < 7'd32) ? item_q.addr[pos_ext[4:0]] : 1'b0;
  assign child     = path_bit ? node.child1 : node.child0;
  assign child_ok  = (child != '0);
  assign pool_full = (next_free_q >= FW'(NODE_COUNT));
  assign route_here = node.route;

  // next state and outputs
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    cur_d        = cur_q;
    lvl_d        = lvl_q;
    node_reg_d   = node_reg_q;
    use_reg_d    = use_reg_q;
    found_d      = found_q;
    best_net_d   = best_net_q;
    best_len_d   = best_len_q;
    next_free_d  = next_free_q;
    count_d      = count_q;
    root_valid_d = root_valid_q;
    res_valid_d  = 1'b0;
    res_status_d = ST_OK;
    res_net_d    = '0;
    res_len_d    = '0;
    res_route_d  = 1'b0;
    res_count_d  = CountW'(count_q);
    item_pop_o   = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = child;
    wr_en        = 1'b0;
    wr_addr      = cur_q;
    wr_data      = node;
    upd          = node;

    case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (item_i.cmd == CMD_CLEAR) begin
            next_free_d  = FW'(1);
            count_d      = '0;
            root_valid_d = 1'b0;
            res_valid_d  = 1'b1;
            res_count_d  = '0;
          end else begin
            item_d    = item_i;
            cur_d     = '0;
            lvl_d     = '0;
            use_reg_d = 1'b0;
            found_d   = 1'b0;
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_d   = BK_WALK;
          end
        end
      end

      BK_WALK: begin
        case (item_q.cmd)
          CMD_LOOKUP: begin
            if (route_here) begin
              found_d    = 1'b1;
              best_net_d = node.net;
              best_len_d = node.len;
            end
            if (lvl_q >= LvlW'(ADDR_BITS) || !child_ok) begin
              res_valid_d  = 1'b1;
              res_status_d = found_d ? ST_OK : ST_MISS;
              res_net_d    = found_d ? best_net_d : '0;
              res_len_d    = found_d ? best_len_d : '0;
              res_route_d  = found_d;
              state_d      = BK_IDLE;
            end else begin
              rd_en     = 1'b1;
              cur_d     = child;
              lvl_d     = lvl_q + 1'b1;
              use_reg_d = 1'b0;
            end
          end

          CMD_ADD: begin
            if (lvl_q < item_q.plen) begin
              if (child_ok) begin
                rd_en     = 1'b1;
                cur_d     = child;
                lvl_d     = lvl_q + 1'b1;
                use_reg_d = 1'b0;
              end else if (pool_full) begin
                // keep a freshly made path node in the pool as it is
                wr_en        = 1'b1;
                res_valid_d  = 1'b1;
                res_status_d = ST_FULL;
                state_d      = BK_IDLE;
              end else begin
                // hang a new empty node under the current one
                if (path_bit) begin
                  upd.child1 = NW'(next_free_q);
                end else begin
                  upd.child0 = NW'(next_free_q);
                end
                wr_en       = 1'b1;
                wr_data     = upd;
                cur_d       = NW'(next_free_q);
                next_free_d = next_free_q + 1'b1;
                node_reg_d  = '0;
                use_reg_d   = 1'b1;
                lvl_d       = lvl_q + 1'b1;
              end
            end else begin
              upd.route = 1'b1;
              upd.net   = item_q.addr;
              upd.len   = LenW'(item_q.plen);
              wr_en     = 1'b1;
              wr_data   = upd;
              if (!node.route) begin
                count_d = count_q + 1'b1;
              end
              res_valid_d  = 1'b1;
              res_net_d    = item_q.addr;
              res_len_d    = LenW'(item_q.plen);
              res_route_d  = 1'b1;
              res_count_d  = CountW'(count_d);
              state_d      = BK_IDLE;
            end
          end

          CMD_FIND: begin
            if (lvl_q < item_q.plen) begin
              if (child_ok) begin
                rd_en     = 1'b1;
                cur_d     = child;
                lvl_d     = lvl_q + 1'b1;
                use_reg_d = 1'b0;
              end else begin
                res_valid_d  = 1'b1;
                res_status_d = ST_MISS;
                state_d      = BK_IDLE;
              end
            end else begin
              res_valid_d = 1'b1;
              res_net_d   = node.net;
              res_len_d   = node.len;
              res_route_d = node.route;
              state_d     = BK_IDLE;
            end
          end

          default: begin
            state_d = BK_IDLE;
          end
        endcase
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase

    // the root reads as empty until it is first written after a clear
    if (wr_en && wr_addr == '0) begin
      root_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      next_free_q  <= FW'(1);
      count_q      <= '0;
      root_valid_q <= 1'b0;
      use_reg_q    <= 1'b0;
      found_q      <= 1'b0;
      res_valid_q  <= 1'b0;
      rd_root_q    <= 1'b1;
    end else begin
      state_q      <= state_d;
      next_free_q  <= next_free_d;
      count_q      <= count_d;
      root_valid_q <= root_valid_d;
      use_reg_q    <= use_reg_d;
      found_q      <= found_d;
      res_valid_q  <= res_valid_d;
      if (rd_en) begin
        rd_root_q <= (rd_addr == '0) && !root_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    cur_q        <= cur_d;
    lvl_q        <= lvl_d;
    node_reg_q   <= node_reg_d;
    best_net_q   <= best_net_d;
    best_len_q   <= best_len_d;
    res_status_q <= res_status_d;
    res_net_q    <= res_net_d;
    res_len_q    <= res_len_d;
    res_route_q  <= res_route_d;
    res_count_q  <= res_count_d;
  end

  // node memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign done_o        = res_valid_q;
  assign status_o      = res_status_q;
  assign route_net_o   = res_net_q;
  assign route_len_o   = res_len_q;
  assign is_route_o    = res_route_q;
  assign route_count_o = res_count_q;

  // pool allocation never runs past the end
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= FW'(NODE_COUNT))
    else $error("next free node beyond pool");

  // every route sits on its own non-root node or the root
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(count_q) <= CW'(next_free_q))
    else $error("route count exceeds allocated nodes");

  // writes only touch allocated nodes
  a_write_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (FW'(wr_addr) < next_free_q))
    else $error("write to unallocated node");

  // the walk never goes deeper than the address width
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_WALK) |-> (lvl_q <= LvlW'(ADDR_BITS)))
    else $error("walk level out of range");

endmodule

### rtl/binary_trie_longest_prefix_match_core.sv
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match_core
// Route table held as a one-bit-per-level binary trie with longest prefix match.
// ----------------------------------------------------------------------------
// lookup and find read one node memory word per trie level from transfer to
//   result, add reads existing nodes and builds new ones in a register; clear
//   is answered from the idle state; the back end walks one command at a time
// a two-entry command queue lets start be taken while a walk is running
// reset empties the table at once, no clearing pass; the receiver cannot stall
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match_core #(
  parameter int unsigned NODE_COUNT = btlpm_pkg::NodeCountDefault,
  parameter int unsigned ADDR_BITS  = btlpm_pkg::AddrBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   command_i,
  input  logic [btlpm_pkg::NetW-1:0]   address_i,
  input  logic [btlpm_pkg::LenW-1:0]   prefix_len_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [btlpm_pkg::NetW-1:0]   route_net_o,
  output logic [btlpm_pkg::LenW-1:0]   route_len_o,
  output logic                         is_route_o,
  output logic [btlpm_pkg::CountW-1:0] route_count_o
);
  import btlpm_pkg::*;

  logic  item_valid;
  item_t item;
  logic  item_pop;

  // command intake and queue
  btlpm_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .address_i    (address_i),
    .prefix_len_i (prefix_len_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // trie walker
  btlpm_back #(
    .NODE_COUNT (NODE_COUNT),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .done_o        (done_o),
    .status_o      (status_o),
    .route_net_o   (route_net_o),
    .route_len_o   (route_len_o),
    .is_route_o    (is_route_o),
    .route_count_o (route_count_o)
  );

endmodule

### dv/binary_trie_longest_prefix_match_core_test.sv
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match_core_test
// Self-checking bench for the trie route table: a behavioural route table
// predicts every result, and a monitor compares each done strobe against it.
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match_core_test;
  import btlpm_pkg::*;

  localparam int unsigned NodeCnt  = 1024;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned CycleCap = 2000000;

  typedef struct packed {
    status_e            status;
    logic [NetW-1:0]    net;
    logic [LenW-1:0]    len;
    logic               is_route;
    logic [CountW-1:0]  count;
  } route_res_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          command_i;
  logic [NetW-1:0]     address_i;
  logic [LenW-1:0]     prefix_len_i;
  logic                done_o;
  logic [1:0]          status_o;
  logic [NetW-1:0]     route_net_o;
  logic [LenW-1:0]     route_len_o;
  logic                is_route_o;
  logic [CountW-1:0]   route_count_o;

  // behavioural copy of the node pool
  int unsigned         kid0_q [NodeCnt];
  int unsigned         kid1_q [NodeCnt];
  bit                  is_rt_q [NodeCnt];
  logic [NetW-1:0]     net_q [NodeCnt];
  logic [LenW-1:0]     len_q [NodeCnt];
  int unsigned         free_node;
  int unsigned         route_total;

  route_res_t          pending_q[$];
  int unsigned         errors;
  int unsigned         cycles;
  int unsigned         n_sent;
  int unsigned         n_checked;
  int unsigned         idle_pct;
  int unsigned         n_full;

  binary_trie_longest_prefix_match_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .address_i, .prefix_len_i,
    .done_o, .status_o, .route_net_o, .route_len_o, .is_route_o, .route_count_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("binary_trie_longest_prefix_match_core_test: FAIL");
      $finish;
    end
  end

  function automatic void table_reset();
    for (int i = 0; i < NodeCnt; i++) begin
      kid0_q[i] = 0; kid1_q[i] = 0; is_rt_q[i] = 0; net_q[i] = '0; len_q[i] = '0;
    end
    free_node   = 1;
    route_total = 0;
  endfunction

  function automatic int unsigned kid(int unsigned n, bit b);
    return b ? kid1_q[n] : kid0_q[n];
  endfunction

  // predicted result of one command, updating the table copy
  function automatic route_res_t route_predict(cmd_e cmd, logic [NetW-1:0] addr,
                                               logic [LenW-1:0] plen_in);
    route_res_t  r;
    int unsigned plen;
    int unsigned cur;
    int unsigned nx;
    int unsigned best;
    bit          found;
    bit          b;
    r    = '0;
    cur  = 0;
    plen = (plen_in > AddrW) ? AddrW : plen_in;
    case (cmd)
      CMD_LOOKUP: begin
        found = 0;
        best  = 0;
        for (int lvl = 0; ; lvl++) begin
          if (is_rt_q[cur]) begin
            found = 1; best = cur;
          end
          if (lvl >= AddrW) break;
          nx = kid(cur, addr[AddrW-1-lvl]);
          if (nx == 0 || nx >= NodeCnt) break;
          cur = nx;
        end
        if (found) begin
          r.status = ST_OK; r.net = net_q[best]; r.len = len_q[best]; r.is_route = 1;
        end else begin
          r.status = ST_MISS;
        end
      end
      CMD_ADD: begin
        for (int lvl = 0; lvl < plen; lvl++) begin
          b  = addr[AddrW-1-lvl];
          nx = kid(cur, b);
          if (nx == 0 || nx >= NodeCnt) begin
            if (free_node >= NodeCnt) begin
              r.status = ST_FULL;
              r.count  = route_total[CountW-1:0];
              return r;
            end
            nx = free_node++;
            kid0_q[nx] = 0; kid1_q[nx] = 0; is_rt_q[nx] = 0;
            net_q[nx] = '0; len_q[nx] = '0;
            if (b) kid1_q[cur] = nx;
            else kid0_q[cur] = nx;
          end
          cur = nx;
        end
        net_q[cur] = addr;
        len_q[cur] = plen[LenW-1:0];
        if (!is_rt_q[cur]) begin
          is_rt_q[cur] = 1; route_total++;
        end
        r.status = ST_OK; r.net = addr; r.len = plen[LenW-1:0]; r.is_route = 1;
      end
      CMD_FIND: begin
        for (int lvl = 0; lvl < plen; lvl++) begin
          nx = kid(cur, addr[AddrW-1-lvl]);
          if (nx == 0 || nx >= NodeCnt) begin
            r.status = ST_MISS;
            r.count  = route_total[CountW-1:0];
            return r;
          end
          cur = nx;
        end
        r.status = ST_OK; r.net = net_q[cur]; r.len = len_q[cur];
        r.is_route = is_rt_q[cur];
      end
      default: table_reset();
    endcase
    r.count = route_total[CountW-1:0];
    return r;
  endfunction

  // send one command, holding start until the transfer
  task automatic send_cmd(cmd_e cmd, logic [NetW-1:0] addr, logic [LenW-1:0] plen);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    command_i    <= cmd;
    address_i    <= addr;
    prefix_len_i <= plen;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_q.push_back(route_predict(cmd, addr, plen));
    if (cmd == CMD_ADD && pending_q[$].status == ST_FULL) n_full++;
    n_sent++;
  endtask

  // compare each result strobe with the oldest prediction
  always @(posedge clk_i) begin
    route_res_t e;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, status_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        n_checked++;
        if (status_o !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, status_o); errors++;
        end
        if (route_net_o !== e.net) begin
          $display("%0t: route_net exp %h got %h", $time, e.net, route_net_o); errors++;
        end
        if (route_len_o !== e.len) begin
          $display("%0t: route_len exp %0d got %0d", $time, e.len, route_len_o); errors++;
        end
        if (is_route_o !== e.is_route) begin
          $display("%0t: is_route exp %0d got %0d", $time, e.is_route, is_route_o); errors++;
        end
        if (route_count_o !== e.count) begin
          $display("%0t: route_count exp %0d got %0d", $time, e.count, route_count_o);
          errors++;
        end
      end
    end
  end

  // random prefix, biased towards short lengths with a few long ones
  function automatic logic [LenW-1:0] rand_len();
    case ($urandom_range(9))
      0:       return LenW'($urandom_range(63));
      1, 2:    return LenW'($urandom_range(32, 24));
      default: return LenW'($urandom_range(8));
    endcase
  endfunction

  // reuse a few base networks so lookups and finds hit existing paths
  function automatic logic [NetW-1:0] rand_addr(logic [NetW-1:0] base);
    case ($urandom_range(3))
      0:       return $urandom;
      default: return base ^ NetW'($urandom_range(255));
    endcase
  endfunction

  task automatic test_directed();
    send_cmd(CMD_LOOKUP, 32'h0, 6'd0);
    send_cmd(CMD_FIND,   32'hFFFF_FFFF, 6'd0);
    send_cmd(CMD_FIND,   32'hFFFF_FFFF, 6'd1);
    send_cmd(CMD_ADD,    32'h0A00_0000, 6'd8);
    send_cmd(CMD_ADD,    32'h0A01_0000, 6'd16);
    send_cmd(CMD_LOOKUP, 32'h0A01_0203, 6'd0);
    send_cmd(CMD_LOOKUP, 32'h0A02_0203, 6'd0);
    send_cmd(CMD_LOOKUP, 32'hC000_0000, 6'd0);
    send_cmd(CMD_FIND,   32'h0A00_0000, 6'd4);
    send_cmd(CMD_ADD,    32'h0A01_0000, 6'd16);
    send_cmd(CMD_ADD,    32'hFFFF_FFFF, 6'd63);
    send_cmd(CMD_FIND,   32'hFFFF_FFFF, 6'd40);
    send_cmd(CMD_ADD,    32'h1234_5678, 6'd0);
    send_cmd(CMD_LOOKUP, 32'h5555_5555, 6'd17);
    send_cmd(CMD_ADD,    32'h0000_0000, 6'd32);
    send_cmd(CMD_LOOKUP, 32'h0000_0000, 6'd0);
    send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0);
    send_cmd(CMD_CLEAR,  32'hAAAA_AAAA, 6'd33);
    send_cmd(CMD_LOOKUP, 32'h0A01_0203, 6'd0);
  endtask

  // fill the pool with long unrelated routes until adds report full
  task automatic test_pool_full();
    send_cmd(CMD_CLEAR, 32'h0, 6'd0);
    while (free_node < NodeCnt) send_cmd(CMD_ADD, $urandom, 6'd32);
    send_cmd(CMD_ADD, $urandom, 6'd32);
    send_cmd(CMD_FIND, 32'h0, 6'd0);
    for (int i = 0; i < 20; i++) send_cmd(cmd_e'($urandom_range(2)), $urandom, rand_len());
    send_cmd(CMD_CLEAR, 32'h0, 6'd0);
  endtask

  task automatic test_random(int unsigned n_items, int unsigned pct);
    logic [NetW-1:0] base;
    int unsigned     pick;
    idle_pct = pct;
    base = $urandom;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 2) send_cmd(CMD_CLEAR, $urandom, LenW'($urandom));
      else if (pick < 40) send_cmd(CMD_ADD, rand_addr(base), rand_len());
      else if (pick < 75) send_cmd(CMD_LOOKUP, rand_addr(base), LenW'($urandom));
      else send_cmd(CMD_FIND, rand_addr(base), rand_len());
      if ($urandom_range(49) == 0) base = $urandom;
    end
    idle_pct = 0;
  endtask

  initial begin
    errors = 0; cycles = 0; n_sent = 0; n_checked = 0; idle_pct = 0; n_full = 0;
    start_i = 1'b0; command_i = '0; address_i = '0; prefix_len_i = '0;
    rst_ni = 1'b0;
    table_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300, 0);
    test_random(280, 83);
    test_random(280, 28);
    test_pool_full();
    test_random(400, 0);
    start_i <= 1'b0;
    // drain
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (AddrW + 8) @(posedge clk_i);
    $display("sent %0d commands, checked %0d results, %0d pool-full adds",
             n_sent, n_checked, n_full);
    $display("covered lookup, add, find and clear with idle gaps and a full pool");
    if (errors == 0) begin
      $display("binary_trie_longest_prefix_match_core_test: PASS");
    end else begin
      $display("binary_trie_longest_prefix_match_core_test: FAIL");
    end
    $finish;
  end

endmodule
